[hw/rtl/wto_pkg.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Widths, codes and the pipeline item type shared by the oscillator modules.
// ----------------------------------------------------------------------------
package wto_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int FRAC_BITS       = 16;
  localparam int PHASE_BITS      = 32;
  localparam int INT_BITS        = PHASE_BITS - FRAC_BITS;
  localparam int LEN_BITS        = 17;
  localparam int STEP_BITS       = 32;
  localparam int IDX_BITS        = 16;
  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 32;
  localparam int IN_DATA_BITS    = IDX_BITS + SAMPLE_BITS;
  localparam int IN_USER_BITS    = 2;
  localparam int OUT_DATA_BITS   = SAMPLE_BITS + IDX_BITS;

  typedef enum logic [IN_USER_BITS-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TABLE_LENGTH  = 2'd0,
    REG_PHASE_STEP    = 2'd1,
    REG_OUTPUT_ENABLE = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_MUTE  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [INT_BITS-1:0]    pos;
    logic [FRAC_BITS-1:0]   frac;
    logic [SAMPLE_BITS-1:0] data;
  } item_t;

endpackage

[hw/rtl/wto_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/wto_modpipe.sv]
// ----------------------------------------------------------------------------
// Phase index reduction pipeline
// Restoring remainder of the integer phase by the table length, one quotient
// bit per stage; write and mute items pass through unchanged.
// ----------------------------------------------------------------------------
module wto_modpipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [wto_pkg::LEN_BITS-1:0] len_i,
  input  logic                         vld_i,
  input  wto_pkg::item_t               item_i,
  output logic                         vld_o,
  output wto_pkg::item_t               item_o
);

  localparam int IW = wto_pkg::INT_BITS;
  localparam int LW = wto_pkg::LEN_BITS;
  localparam int CW = IW + LW;

  logic           vld_q  [IW];
  wto_pkg::item_t item_q [IW];

  for (genvar g = 0; g < IW; g++) begin : g_stage
    logic           src_vld;
    wto_pkg::item_t src;
    wto_pkg::item_t nxt;
    logic [CW-1:0]  sub;

    if (g == 0) begin : g_first
      assign src_vld = vld_i;
      assign src     = item_i;
    end else begin : g_rest
      assign src_vld = vld_q[g-1];
      assign src     = item_q[g-1];
    end

    assign sub = CW'(len_i) << (IW - 1 - g);

    always_comb begin
      nxt = src;
      if (src.op == wto_pkg::OP_TICK && {{LW{1'b0}}, src.pos} >= sub) begin
        nxt.pos = src.pos - sub[IW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[g] <= nxt;
      end
    end
  end

  assign vld_o  = vld_q[IW-1];
  assign item_o = item_q[IW-1];

endmodule

[hw/rtl/wavetable_oscillator_interp.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator with linear interpolation
// An accepted tick item reaches m_axis through 16 remainder stages, the table
// read, the difference and product stages and the output register.
// Throughput: one item per cycle; the pipeline holds only while the output
// skid register is full. Reset clears the phase, the pipeline and the
// registers to length 65536, step 1.0 and output on; the table is not cleared.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp #(
  parameter int TABLE_DEPTH = wto_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index, entry_value
  input  logic [wto_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // mode
  input  logic [wto_pkg::IN_USER_BITS-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_sample, read_position
  output logic [wto_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [wto_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [wto_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SB = wto_pkg::SAMPLE_BITS;
  localparam int FB = wto_pkg::FRAC_BITS;
  localparam int LW = wto_pkg::LEN_BITS;
  localparam int IB = wto_pkg::IDX_BITS;
  localparam int DW = SB + 1;
  localparam int PW = DW + FB + 1;
  localparam int SPW = LW + FB;
  localparam logic [LW-1:0] LEN_MIN = LW'(2);
  localparam logic [LW-1:0] LEN_MAX =
    (TABLE_DEPTH > 131071) ? {LW{1'b1}} : LW'(TABLE_DEPTH);
  localparam logic [LW-1:0] LEN_RST =
    (TABLE_DEPTH < 65536) ? LW'(TABLE_DEPTH) : LW'(65536);

  // configuration
  logic [LW-1:0]                 len_q;
  logic [wto_pkg::STEP_BITS-1:0] step_q;
  logic                          out_en_q;
  logic [LW-1:0]                 len_wr;

  always_comb begin
    len_wr = cfg_data_i[LW-1:0];
    if (len_wr < LEN_MIN) begin
      len_wr = LEN_MIN;
    end else if (32'(len_wr) > 32'(TABLE_DEPTH)) begin
      len_wr = LEN_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_RST;
      step_q   <= wto_pkg::STEP_BITS'(65536);
      out_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (wto_pkg::reg_e'(cfg_idx_i))
        wto_pkg::REG_TABLE_LENGTH:  len_q    <= len_wr;
        wto_pkg::REG_PHASE_STEP:    step_q   <= cfg_data_i;
        wto_pkg::REG_OUTPUT_ENABLE: out_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // flow control
  logic en;
  logic skid_vld_q;
  logic acc;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  // phase accumulator and item entry
  logic [wto_pkg::PHASE_BITS-1:0] phase_q, phase_d;
  logic [wto_pkg::PHASE_BITS:0]   sum;
  logic [wto_pkg::PHASE_BITS:0]   span;
  logic [IB-1:0]                  in_idx;
  logic [SB-1:0]                  in_val;
  logic                           in_vld;
  wto_pkg::item_t                 in_item;

  assign in_idx = s_axis_tdata[IB-1:0];
  assign in_val = s_axis_tdata[IB+SB-1:IB];
  assign sum    = {1'b0, phase_q} + {1'b0, step_q};
  assign span   = (wto_pkg::PHASE_BITS+1)'({len_q, {FB{1'b0}}});

  always_comb begin
    phase_d      = phase_q;
    in_vld       = 1'b0;
    in_item.op   = wto_pkg::OP_WRITE;
    in_item.pos  = phase_q[wto_pkg::PHASE_BITS-1:FB];
    in_item.frac = phase_q[FB-1:0];
    in_item.data = in_val;
    unique case (wto_pkg::mode_e'(s_axis_tuser))
      wto_pkg::MODE_WRITE: begin
        in_item.pos = wto_pkg::INT_BITS'(in_idx);
        in_vld      = acc && (32'(in_idx) < 32'(TABLE_DEPTH));
      end
      wto_pkg::MODE_TICK: begin
        in_vld = acc;
        if (out_en_q) begin
          in_item.op = wto_pkg::OP_TICK;
          if (acc) begin
            phase_d = (sum >= span) ? phase_q - span[wto_pkg::PHASE_BITS-1:0] + step_q
                                    : sum[wto_pkg::PHASE_BITS-1:0];
          end
        end else begin
          in_item.op  = wto_pkg::OP_MUTE;
          in_item.pos = '0;
        end
      end
      wto_pkg::MODE_RESTART: begin
        if (acc) begin
          phase_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // index reduction
  logic           m_vld;
  wto_pkg::item_t m_item;

  wto_modpipe u_modpipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .len_i  (len_q),
    .vld_i  (in_vld),
    .item_i (in_item),
    .vld_o  (m_vld),
    .item_o (m_item)
  );

  // table access
  logic [LW-1:0] inc;
  logic [LW-1:0] nxt;
  logic          tbl_we;
  logic [SB-1:0] rd_a, rd_b;

  assign inc    = LW'(m_item.pos) + LW'(1);
  assign nxt    = (inc == len_q) ? '0 : inc;
  assign tbl_we = en && m_vld && (m_item.op == wto_pkg::OP_WRITE);

  wto_ram #(
    .WIDTH (SB),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(m_item.pos)),
    .wdata_i (m_item.data),
    .re_i    (en),
    .raddr_i (AW'(m_item.pos)),
    .rdata_o (rd_a)
  );

  wto_ram #(
    .WIDTH (SB),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(m_item.pos)),
    .wdata_i (m_item.data),
    .re_i    (en),
    .raddr_i (AW'(nxt)),
    .rdata_o (rd_b)
  );

  logic           r_vld_q;
  wto_pkg::item_t r_item_q;

  // difference stage
  logic                   d_vld_q;
  wto_pkg::op_e           d_op_q;
  logic [IB-1:0]          d_pos_q;
  logic [FB-1:0]          d_frac_q;
  logic signed [DW-1:0]   d_diff_q, d_diff_d;
  logic signed [SB-1:0]   d_base_q;

  assign d_diff_d = DW'(signed'(rd_b)) - DW'(signed'(rd_a));

  // product stage
  logic                   p_vld_q;
  wto_pkg::op_e           p_op_q;
  logic [IB-1:0]          p_pos_q;
  logic signed [SB-1:0]   p_base_q;
  logic signed [PW-1:0]   p_prod_q, p_prod_d;
  logic signed [FB:0]     d_frac_s;

  assign d_frac_s = signed'({1'b0, d_frac_q});
  assign p_prod_d = d_diff_q * d_frac_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= m_vld && (m_item.op != wto_pkg::OP_WRITE);
      d_vld_q <= r_vld_q;
      p_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_item_q <= m_item;
      d_op_q   <= r_item_q.op;
      d_pos_q  <= IB'(r_item_q.pos);
      d_frac_q <= r_item_q.frac;
      d_diff_q <= d_diff_d;
      d_base_q <= signed'(rd_a);
      p_op_q   <= d_op_q;
      p_pos_q  <= d_pos_q;
      p_base_q <= d_base_q;
      p_prod_q <= p_prod_d;
    end
  end

  // result
  logic signed [PW-1:0] p_shift;
  logic signed [PW-1:0] y_sum;
  logic                 res_vld;
  logic [SB-1:0]        res_sample;
  logic [IB-1:0]        res_pos;

  assign p_shift    = p_prod_q >>> FB;
  assign y_sum      = PW'(p_base_q) + p_shift;
  assign res_vld    = en && p_vld_q;
  assign res_sample = (p_op_q == wto_pkg::OP_TICK) ? y_sum[SB-1:0] : '0;
  assign res_pos    = (p_op_q == wto_pkg::OP_TICK) ? p_pos_q : '0;

  // output register and skid
  logic                              out_vld_q;
  logic [wto_pkg::OUT_DATA_BITS-1:0] out_data_q;
  logic [wto_pkg::OUT_DATA_BITS-1:0] skid_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= res_vld;
      end
    end else if (res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_data_q <= skid_vld_q ? skid_data_q : {res_pos, res_sample};
    end else if (res_vld) begin
      skid_data_q <= {res_pos, res_sample};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[sim/wavetable_oscillator_interp_checker.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator checker
// Watches the configuration port and both stream channels. It keeps its own
// table, phase and registers, predicts the interpolated sample and read
// position of every accepted tick, and compares each result with the oldest
// prediction. Reports the number of predictions still waiting and the number
// of mismatches.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp_checker
  import wto_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  // entry_index, entry_value
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // mode
  input  logic [IN_USER_BITS-1:0]  s_axis_tuser,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // out_sample, read_position
  input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int                       pending_o,
  output int                       fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [IDX_BITS-1:0]    position;
    logic [SAMPLE_BITS-1:0] sample;
  } osc_result_t;

  logic signed [SAMPLE_BITS-1:0] wave_mem [TABLE_DEPTH_DEF];
  logic [PHASE_BITS-1:0]         phase_acc;
  logic [LEN_BITS-1:0]           length_reg;
  logic [STEP_BITS-1:0]          step_reg;
  logic                          enable_reg;
  osc_result_t                   expected_results [$];
  int                            errors = 0;
  int                            results_seen = 0;

  task automatic report_mismatch(string what, int want, int got);
    if (errors < MAX_PRINTED) begin
      $display("MISMATCH %s: expected %0d, got %0d (result %0d)", what, want, got,
               results_seen);
    end
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    longint          used_len;
    longint          pos;
    longint          nxt;
    longint          frac_v;
    longint          a;
    longint          b;
    longint          y;
    longint unsigned sum;
    longint unsigned span;
    osc_result_t     want;
    osc_result_t     got;
    if (!rst_ni) begin
      phase_acc  = '0;
      length_reg = LEN_BITS'(TABLE_DEPTH_DEF);
      step_reg   = STEP_BITS'(32'h0001_0000);
      enable_reg = 1'b1;
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TABLE_LENGTH:  length_reg = cfg_data_i[LEN_BITS-1:0];
          REG_PHASE_STEP:    step_reg = cfg_data_i[STEP_BITS-1:0];
          REG_OUTPUT_ENABLE: enable_reg = cfg_data_i[0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          MODE_WRITE: begin
            wave_mem[s_axis_tdata[IDX_BITS-1:0]] = s_axis_tdata[IN_DATA_BITS-1:IDX_BITS];
          end
          MODE_RESTART: phase_acc = '0;
          MODE_TICK: begin
            if (!enable_reg) begin
              want = '0;
            end else begin
              used_len = longint'(length_reg);
              if (used_len < 2) used_len = 2;
              if (used_len > TABLE_DEPTH_DEF) used_len = TABLE_DEPTH_DEF;
              pos    = longint'(phase_acc[PHASE_BITS-1:FRAC_BITS]);
              pos    = pos % used_len;
              nxt    = (pos + 1 == used_len) ? 0 : pos + 1;
              frac_v = longint'(phase_acc[FRAC_BITS-1:0]);
              a      = longint'(wave_mem[pos[IDX_BITS-1:0]]);
              b      = longint'(wave_mem[nxt[IDX_BITS-1:0]]);
              y      = a + (((b - a) * frac_v) >>> FRAC_BITS);
              span   = 64'(used_len) << FRAC_BITS;
              sum    = 64'(phase_acc) + 64'(step_reg);
              if (sum >= span) sum -= span;
              phase_acc     = sum[PHASE_BITS-1:0];
              want.sample   = y[SAMPLE_BITS-1:0];
              want.position = pos[IDX_BITS-1:0];
            end
            expected_results.push_back(want);
          end
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item, out_sample", 0, int'($signed(got.sample)));
        end else begin
          want = expected_results.pop_front();
          if (got.sample !== want.sample) begin
            report_mismatch("out_sample", int'($signed(want.sample)),
                            int'($signed(got.sample)));
          end
          if (got.position !== want.position) begin
            report_mismatch("read_position", int'(want.position), int'(got.position));
          end
        end
      end

      pending_o    <= expected_results.size();
      fail_count_o <= errors;
    end
  end

endmodule

[sim/wavetable_oscillator_interp_tb.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator testbench
// Resets the oscillator, runs a short directed sequence over sample extremes,
// every mode, wrap, oversized step, disable and restart, then a series of
// register settings with random writes, ticks and restarts. Entries are
// written before any tick can read them. Sender gaps and receiver stalls come
// in random bursts, with one long receiver hold-off; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wto_pkg::*;

  localparam logic [IN_USER_BITS-1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES     = 30;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TIMEOUT_CYCLES   = 1_000_000;
  localparam int NUM_PHASES       = 12;
  localparam int PRESSURE_PHASE   = 7;

  localparam int unsigned PH_LEN [NUM_PHASES] =
    '{16, 65536, 3, 0, 131071, 1, 8, 32, 65535, 5, 64, 12};
  localparam int unsigned PH_STEP [NUM_PHASES] =
    '{0, 32'hFFFF_FFFF, 0, 0, 0, 32'h0001_8000, 0, 0, 0, 32'h0000_0001, 0, 0};
  localparam bit PH_RAND_STEP [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 1, 1, 0, 1, 1};
  localparam bit PH_EN [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1};
  localparam int PH_ITEMS [NUM_PHASES] =
    '{170, 130, 170, 90, 140, 110, 90, 200, 170, 130, 170, 230};
  localparam int PH_GAP [NUM_PHASES] = '{10, 0, 25, 5, 15, 10, 10, 0, 20, 10, 10, 0};
  localparam int PH_STALL [NUM_PHASES] = '{10, 0, 25, 40, 5, 10, 10, 0, 20, 10, 10, 0};

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  logic [IN_USER_BITS-1:0]  s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;
  int                       pending;
  int                       fail_count;

  logic [PHASE_BITS-1:0] shadow_phase;
  int unsigned           shadow_len;
  logic [STEP_BITS-1:0]  shadow_step;
  bit                    shadow_en;
  bit                    written [TABLE_DEPTH_DEF];
  int                    tx_gap_pct = 0;
  int                    rx_stall_pct = 0;
  bit                    long_hold_req = 1'b0;
  int                    cycle_count = 0;

  always #5 clk_i = ~clk_i;

  wavetable_oscillator_interp u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  wavetable_oscillator_interp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left;
    int stall_left;
    bit hold_seen;
    hold_left  = 0;
    stall_left = 0;
    hold_seen  = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req != hold_seen) begin
        hold_seen = long_hold_req;
        hold_left = LONG_HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(99, 0) < rx_stall_pct) begin
        stall_left = $urandom_range(19, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [IN_USER_BITS-1:0] kind, logic [IDX_BITS-1:0] idx,
                           logic [SAMPLE_BITS-1:0] val);
    if (tx_gap_pct > 0 && $urandom_range(99, 0) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, idx};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_entry(int unsigned idx, logic [SAMPLE_BITS-1:0] val);
    send_item(MODE_WRITE, idx[IDX_BITS-1:0], val);
    written[idx[IDX_BITS-1:0]] = 1'b1;
  endtask

  task automatic restart_phase();
    send_item(MODE_RESTART, IDX_BITS'($urandom), SAMPLE_BITS'($urandom));
    shadow_phase = '0;
  endtask

  // send a tick, first writing the two entries it reads if enabled and unknown
  task automatic tick();
    int unsigned     pos;
    int unsigned     nxt;
    longint unsigned sum;
    longint unsigned span;
    if (shadow_en) begin
      pos = shadow_phase[PHASE_BITS-1:FRAC_BITS] % shadow_len;
      nxt = (pos + 1 == shadow_len) ? 0 : pos + 1;
      if (!written[pos[IDX_BITS-1:0]]) write_entry(pos, SAMPLE_BITS'($urandom));
      if (!written[nxt[IDX_BITS-1:0]]) write_entry(nxt, SAMPLE_BITS'($urandom));
    end
    send_item(MODE_TICK, IDX_BITS'($urandom), SAMPLE_BITS'($urandom));
    if (shadow_en) begin
      span = 64'(shadow_len) << FRAC_BITS;
      sum  = 64'(shadow_phase) + 64'(shadow_step);
      if (sum >= span) sum -= span;
      shadow_phase = sum[PHASE_BITS-1:0];
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned len, logic [STEP_BITS-1:0] step, bit en);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TABLE_LENGTH;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i  <= REG_PHASE_STEP;
    cfg_data_i <= step;
    @(posedge clk_i);
    cfg_idx_i  <= REG_OUTPUT_ENABLE;
    cfg_data_i <= CFG_DATA_BITS'(en);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_len  = (len < 2) ? 2 : (len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : len;
    shadow_step = step;
    shadow_en   = en;
  endtask

  initial begin : stimulus
    int                   sel;
    logic [STEP_BITS-1:0] step;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_TABLE_LENGTH;
    cfg_data_i    <= '0;
    shadow_phase = '0;
    shadow_len   = TABLE_DEPTH_DEF;
    shadow_step  = 32'h0001_0000;
    shadow_en    = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_entry(0, 16'h7FFF);
    write_entry(1, 16'h8000);
    write_entry(16'hFFFF, 16'h8000);
    write_entry(2, 16'h0001);
    tick();
    tick();
    send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
    restart_phase();
    tick();
    configure(2, 32'h0000_FFFF, 1'b1);
    tick();
    tick();
    tick();
    tick();
    write_entry(0, 16'h8000);
    write_entry(1, 16'h7FFF);
    tick();
    tick();
    configure(TABLE_DEPTH_DEF, 32'hFFFF_FFFF, 1'b1);
    tick();
    tick();
    configure(TABLE_DEPTH_DEF, 32'h0001_0000, 1'b0);
    tick();
    restart_phase();
    tick();
    configure(TABLE_DEPTH_DEF, 32'h0001_0000, 1'b1);
    tick();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (!PH_RAND_STEP[p]) step = PH_STEP[p];
      else if (PH_LEN[p] >= TABLE_DEPTH_DEF) step = $urandom;
      else step = $urandom_range(PH_LEN[p] * 65536 - 1, 0);
      configure(PH_LEN[p], step, PH_EN[p]);
      tx_gap_pct = PH_GAP[p];
      rx_stall_pct <= PH_STALL[p];
      for (int i = 0; i < PH_ITEMS[p]; i++) begin
        if (p == PRESSURE_PHASE && i == 0) long_hold_req <= 1'b1;
        if (p == PRESSURE_PHASE && i == PH_ITEMS[p] / 2) wait_drained();
        sel = $urandom_range(99, 0);
        if (p == PRESSURE_PHASE || sel < 55) begin
          tick();
        end else if (sel < 85) begin
          if ($urandom_range(4, 0) == 0) begin
            write_entry($urandom_range(65535, 0), SAMPLE_BITS'($urandom));
          end else begin
            write_entry($urandom_range(shadow_len - 1, 0), SAMPLE_BITS'($urandom));
          end
        end else if (sel < 95) begin
          restart_phase();
        end else begin
          send_item(MODE_UNUSED, IDX_BITS'($urandom), SAMPLE_BITS'($urandom));
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/wto_pkg.sv
hw/rtl/wto_ram.sv
hw/rtl/wto_modpipe.sv
hw/rtl/wavetable_oscillator_interp.sv
sim/wavetable_oscillator_interp_checker.sv
sim/wavetable_oscillator_interp_tb.sv
